FILE: sv/efqr_pkg.sv
// efqr_pkg: request codes, event codes and the event entry type for the
// event fork queue recorder. No dependencies.
package efqr_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_START = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  localparam logic [1:0]  CODE_KEY  = 2'd0;
  localparam logic [1:0]  CODE_TICK = 2'd1;
  localparam logic [31:0] STOP_KEY  = 32'h0000_2b1c;
  localparam logic [31:0] KEY_MASK  = 32'h0000_ffff;

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] data;
  } evt_t;

endpackage

FILE: sv/efqr_ram.sv
// efqr_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module efqr_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/event_fork_queue_recorder_unit.sv
// event_fork_queue_recorder_unit: event queue with macro recorder, top level.
// Depends on efqr_pkg and efqr_ram (queue store and record store).
//
// One request beat is taken every cycle while the output is not stalled. A
// result beat passes through the registered read of the queue and record
// memories and then through the output register. Queue pointers move when
// the request is accepted; the recorder state moves when the request leaves
// the memory-read stage, with a forwarding register covering a read of the
// entry written just before. Both stores start undefined, so there is no
// clearing pass after reset. Output stalls back up through the read stage
// to s_tready.
module event_fork_queue_recorder_unit
  import efqr_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 32,
  parameter int RECORD_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] event_code, [33:2] event_data, [42:34] record_count,
  // [50:43] read_index, [55:51] zero
  input  logic [55:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] accepted, [1] event_valid, [3:2] out_code, [35:4] out_data,
  // [41:36] queue_count, [42] recording, [51:43] record_remaining,
  // [60:52] record_used, [63:61] zero
  output logic [63:0] m_tdata
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QFW = $clog2(QUEUE_DEPTH + 1);
  localparam int RAW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int WPW = $clog2(RECORD_DEPTH + 1);

  // input fields
  logic [1:0]  in_code;
  logic [31:0] in_data;
  logic [8:0]  in_count;
  logic [7:0]  in_idx;
  req_t        in_req;

  assign in_code  = s_tdata[1:0];
  assign in_data  = s_tdata[33:2];
  assign in_count = s_tdata[42:34];
  assign in_idx   = s_tdata[50:43];
  assign in_req   = req_t'(s_tuser);

  // queue control
  logic [QAW-1:0] head, head_next;
  logic [QAW-1:0] tail, tail_next;
  logic [QFW-1:0] fill, fill_next;
  logic           enq_ok, deq_ok;

  // read stage
  logic           v1;
  req_t           req1;
  logic           enq1, deq1;
  logic [QFW-1:0] fill1;
  logic [8:0]     count1;
  logic [7:0]     idx1;
  logic           fwd_hit1;
  evt_t           fwd_data1;

  // recorder state
  logic           rec_on, rec_on_next;
  logic [WPW-1:0] wp, wp_next;
  logic [WPW-1:0] left, left_next;
  logic           last_tick, last_tick_next;
  logic [31:0]    last_data, last_data_next;

  // output register
  logic           ov;
  logic [63:0]    o_data, o_data_next;

  logic           accept, advance;
  evt_t           q_rdata, r_rdata;
  logic           rec_we;
  logic [RAW-1:0] rec_waddr, rd_addr;
  evt_t           rec_wdata;
  logic [RAW+7:0] idx_wide;

  assign advance  = v1 && (!ov || m_tready);
  assign s_tready = !v1 || advance;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = ov;
  assign m_tdata  = o_data;

  assign enq_ok = (in_req == REQ_ENQ) && (fill < QFW'(QUEUE_DEPTH));
  assign deq_ok = (in_req == REQ_DEQ) && (fill != '0);

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    if (accept && enq_ok) begin
      tail_next = (tail == QAW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      fill_next = fill + 1'b1;
    end
    if (accept && deq_ok) begin
      head_next = (head == QAW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      fill_next = fill - 1'b1;
    end
  end

  efqr_ram #(
    .WIDTH($bits(evt_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (accept && enq_ok),
    .waddr(tail),
    .wdata({in_code, in_data}),
    .re   (accept && deq_ok),
    .raddr(head),
    .rdata(q_rdata)
  );

  assign idx_wide = {{RAW{1'b0}}, in_idx};
  assign rd_addr  = idx_wide[RAW-1:0];

  efqr_ram #(
    .WIDTH($bits(evt_t)),
    .DEPTH(RECORD_DEPTH)
  ) u_record_ram (
    .clk  (clk),
    .we   (rec_we),
    .waddr(rec_waddr),
    .wdata(rec_wdata),
    .re   (accept && (in_req == REQ_READ)),
    .raddr(rd_addr),
    .rdata(r_rdata)
  );

  // recorder and result assembly for the beat in the read stage
  logic           r_acc, r_valid;
  evt_t           r_ev;
  logic [WPW-1:0] wp_m1;
  logic [WPW+8:0] cnt_wide;
  logic [WPW+7:0] idx_cmp, wp_cmp;
  logic [QFW+5:0] qc_wide;
  logic [WPW+8:0] left_wide, wp_wide;

  assign wp_m1    = wp - 1'b1;
  assign cnt_wide = {{WPW{1'b0}}, count1};
  assign idx_cmp  = {{WPW{1'b0}}, idx1};
  assign wp_cmp   = {8'd0, wp};

  always_comb begin
    rec_on_next    = rec_on;
    wp_next        = wp;
    left_next      = left;
    last_tick_next = last_tick;
    last_data_next = last_data;
    rec_we         = 1'b0;
    rec_waddr      = wp[RAW-1:0];
    rec_wdata      = '0;
    r_acc          = 1'b0;
    r_valid        = 1'b0;
    r_ev           = '0;
    unique case (req1)
      REQ_ENQ: begin
        r_acc = enq1;
      end
      REQ_DEQ: begin
        if (deq1) begin
          r_valid = 1'b1;
          r_ev    = q_rdata;
          if (rec_on) begin
            if (q_rdata.code == CODE_KEY && (q_rdata.data & KEY_MASK) == STOP_KEY) begin
              rec_on_next = 1'b0;
            end else if (q_rdata.code == CODE_TICK && last_tick && wp != '0) begin
              // timer run: fold into the entry just written
              rec_we         = 1'b1;
              rec_waddr      = wp_m1[RAW-1:0];
              rec_wdata      = {CODE_TICK, last_data + q_rdata.data};
              last_data_next = last_data + q_rdata.data;
            end else if (left == '0 || wp == WPW'(RECORD_DEPTH)) begin
              rec_on_next = 1'b0;
            end else begin
              rec_we         = 1'b1;
              rec_wdata      = q_rdata;
              wp_next        = wp + 1'b1;
              left_next      = left - 1'b1;
              last_tick_next = (q_rdata.code == CODE_TICK);
              last_data_next = q_rdata.data;
              rec_on_next    = (left != WPW'(1));
            end
          end
        end
      end
      REQ_START: begin
        wp_next        = '0;
        last_tick_next = 1'b0;
        if (cnt_wide > (WPW + 9)'(RECORD_DEPTH)) begin
          left_next = WPW'(RECORD_DEPTH);
        end else begin
          left_next = cnt_wide[WPW-1:0];
        end
        rec_on_next = (left_next != '0);
      end
      REQ_READ: begin
        if (idx_cmp < wp_cmp) begin
          r_valid = 1'b1;
          r_ev    = fwd_hit1 ? fwd_data1 : r_rdata;
        end
      end
      default: ;
    endcase
    rec_we = rec_we && advance;
  end

  assign qc_wide   = {6'd0, fill1};
  assign left_wide = {9'd0, left_next};
  assign wp_wide   = {9'd0, wp_next};

  always_comb begin
    o_data_next = {3'd0, wp_wide[8:0], left_wide[8:0], rec_on_next, qc_wide[5:0],
                   r_ev.data, r_ev.code, r_valid, r_acc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      v1        <= 1'b0;
      ov        <= 1'b0;
      rec_on    <= 1'b0;
      wp        <= '0;
      left      <= '0;
      last_tick <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
      if (s_tready) begin
        v1 <= accept;
      end
      if (advance) begin
        ov        <= 1'b1;
        rec_on    <= rec_on_next;
        wp        <= wp_next;
        left      <= left_next;
        last_tick <= last_tick_next;
      end else if (m_tready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req1      <= in_req;
      enq1      <= enq_ok;
      deq1      <= deq_ok;
      fill1     <= fill_next;
      count1    <= in_count;
      idx1      <= in_idx;
      // record write landing in the same cycle as this read
      fwd_hit1  <= rec_we && (rec_waddr == rd_addr);
      fwd_data1 <= rec_wdata;
    end
    if (advance) begin
      last_data <= last_data_next;
      o_data    <= o_data_next;
    end
  end

endmodule
